### rtl/keypoint_grid_radius_search_top_defines.svh
// Assertion helpers for the keypoint grid search block.
`ifndef KEYPOINT_GRID_RADIUS_SEARCH_TOP_DEFINES_SVH
`define KEYPOINT_GRID_RADIUS_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define KGRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define KGRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/kgrs_pkg.sv
package kgrs_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int GRID_COLS = 64;
  localparam int GRID_ROWS = 48;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CELL_W    = 6;
  localparam int FRAC_BITS = 20;
  localparam int PROD_W    = 35;
  localparam int WIN_W     = 16;
  localparam int SORT_W    = 2 * CELL_W + IDX_W;
  localparam int QDEPTH    = 2;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_QUERY  = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OUTSIDE = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOHIT   = 2'd3;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_INV_W    = 2'd2;
  localparam logic [1:0] CFG_INV_H    = 2'd3;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        inv_w;
    logic [15:0]        inv_h;
  } cfg_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [15:0]       px;
    logic signed [15:0]       py;
    logic [2:0]               octave;
    logic [14:0]              radius;
    logic signed [3:0]        min_level;
    logic signed [3:0]        max_level;
    logic signed [WIN_W-1:0]  c0;
    logic signed [WIN_W-1:0]  c1;
    logic signed [WIN_W-1:0]  r0;
    logic signed [WIN_W-1:0]  r1;
    logic [CELL_W-1:0]        col;
    logic [CELL_W-1:0]        row;
    logic                     in_grid;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [2:0]         level;
    logic [CELL_W-1:0]  col;
    logic [CELL_W-1:0]  row;
    logic               in_grid;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } bstat_t;

endpackage

### rtl/kgrs_front.sv
module kgrs_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [2:0]         octave_i,
  input  logic [14:0]        radius_i,
  input  logic signed [3:0]  min_level_i,
  input  logic signed [3:0]  max_level_i,
  input  kgrs_pkg::cfg_t     cfg_i,
  input  kgrs_pkg::qstat_t   qstat_i,
  output logic               push_o,
  output kgrs_pkg::cmd_t     cmd_o
);
  import kgrs_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0] stage_q, stage_d;
  logic [1:0] kind_q;
  logic signed [15:0] px_q, py_q;
  logic [2:0] oct_q;
  logic [14:0] rad_q;
  logic signed [3:0] minl_q, maxl_q;
  logic signed [PROD_W-1:0] plo_x_q, phi_x_q, plo_y_q, phi_y_q;

  logic [14:0] rad_eff;
  logic signed [16:0] dx, dy;
  logic signed [17:0] dlo_x, dhi_x, dlo_y, dhi_y;
  logic signed [PROD_W-1:0] plo_x, phi_x, plo_y, phi_y;
  logic [PROD_W-1:0] mag_x, mag_y, sum_x, sum_y;
  logic [14:0] qx, qy;
  logic in_x, in_y;
  logic signed [PROD_W:0] cx1, cy1;

  assign in_ready_o = (stage_q == F_IDLE);

  // Multiply stage: window edges (radius forced to zero for all but queries).
  always_comb begin
    rad_eff = (kind_q == REQ_QUERY) ? rad_q : 15'd0;
    dx    = 17'(px_q) - 17'(cfg_i.origin_x);
    dy    = 17'(py_q) - 17'(cfg_i.origin_y);
    dlo_x = 18'(dx) - $signed({3'b000, rad_eff});
    dhi_x = 18'(dx) + $signed({3'b000, rad_eff});
    dlo_y = 18'(dy) - $signed({3'b000, rad_eff});
    dhi_y = 18'(dy) + $signed({3'b000, rad_eff});
    plo_x = PROD_W'(dlo_x) * PROD_W'($signed({1'b0, cfg_i.inv_w}));
    phi_x = PROD_W'(dhi_x) * PROD_W'($signed({1'b0, cfg_i.inv_w}));
    plo_y = PROD_W'(dlo_y) * PROD_W'($signed({1'b0, cfg_i.inv_h}));
    phi_y = PROD_W'(dhi_y) * PROD_W'($signed({1'b0, cfg_i.inv_h}));
  end

  // Cell stage: round half away from zero for inserts, floor/ceil for queries.
  always_comb begin
    mag_x = plo_x_q[PROD_W-1] ? 35'(-plo_x_q) : 35'(plo_x_q);
    mag_y = plo_y_q[PROD_W-1] ? 35'(-plo_y_q) : 35'(plo_y_q);
    sum_x = mag_x + (35'd1 << (FRAC_BITS - 1));
    sum_y = mag_y + (35'd1 << (FRAC_BITS - 1));
    qx    = sum_x[PROD_W-1:FRAC_BITS];
    qy    = sum_y[PROD_W-1:FRAC_BITS];
    in_x  = (!plo_x_q[PROD_W-1] || qx == 15'd0) && (qx < 15'(GRID_COLS));
    in_y  = (!plo_y_q[PROD_W-1] || qy == 15'd0) && (qy < 15'(GRID_ROWS));
    cx1   = 36'(phi_x_q) + 36'((64'd1 << FRAC_BITS) - 64'd1);
    cy1   = 36'(phi_y_q) + 36'((64'd1 << FRAC_BITS) - 64'd1);

    cmd_o.kind      = kind_q;
    cmd_o.px        = px_q;
    cmd_o.py        = py_q;
    cmd_o.octave    = oct_q;
    cmd_o.radius    = rad_q;
    cmd_o.min_level = minl_q;
    cmd_o.max_level = maxl_q;
    cmd_o.c0        = {plo_x_q[PROD_W-1], plo_x_q[PROD_W-1:FRAC_BITS]};
    cmd_o.r0        = {plo_y_q[PROD_W-1], plo_y_q[PROD_W-1:FRAC_BITS]};
    cmd_o.c1        = cx1[PROD_W:FRAC_BITS];
    cmd_o.r1        = cy1[PROD_W:FRAC_BITS];
    cmd_o.in_grid   = in_x && in_y;
    cmd_o.col       = (in_x && in_y) ? qx[CELL_W-1:0] : '0;
    cmd_o.row       = (in_x && in_y) ? qy[CELL_W-1:0] : '0;
  end

  assign push_o = (stage_q == F_PUSH) && !qstat_i.full && (kind_q != REQ_NONE);

  always_comb begin
    stage_d = stage_q;
    case (stage_q)
      F_IDLE: if (in_valid_i) stage_d = F_MUL;
      F_MUL:  stage_d = F_PUSH;
      F_PUSH: if (!qstat_i.full || kind_q == REQ_NONE) stage_d = F_IDLE;
      default: stage_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= F_IDLE;
    end else begin
      stage_q <= stage_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_q == F_IDLE && in_valid_i) begin
      kind_q <= req_type_i;
      px_q   <= point_x_i;
      py_q   <= point_y_i;
      oct_q  <= octave_i;
      rad_q  <= radius_i;
      minl_q <= min_level_i;
      maxl_q <= max_level_i;
    end
    if (stage_q == F_MUL) begin
      plo_x_q <= plo_x;
      phi_x_q <= phi_x;
      plo_y_q <= plo_y;
      phi_y_q <= phi_y;
    end
  end

endmodule

### rtl/kgrs_queue.sv
module kgrs_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kgrs_pkg::cmd_t   cmd_i,
  input  logic             pop_i,
  output kgrs_pkg::cmd_t   head_o,
  output kgrs_pkg::qstat_t qstat_o
);
  import kgrs_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  cmd_t slots_q [QDEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0] fill_q;

  assign head_o        = slots_q[rd_q];
  assign qstat_o.full  = (fill_q == (PTR_W+1)'(QDEPTH));
  assign qstat_o.empty = (fill_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      fill_q <= fill_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_q] <= cmd_i;
  end

endmodule

### rtl/kgrs_back.sv
module kgrs_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  kgrs_pkg::cmd_t   head_i,
  input  kgrs_pkg::qstat_t qstat_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [5:0]       key_index_o,
  output logic             index_valid_o,
  output logic [1:0]       status_o,
  output logic             last_o,
  output kgrs_pkg::bstat_t stat_o
);
  import kgrs_pkg::*;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_SCAN = 2'd1;
  localparam logic [1:0] B_END  = 2'd2;

  entry_t mem [MAX_KEYS];
  entry_t rd_q, wdata;
  logic we;

  logic [1:0] state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d, addr_q, addr_d;
  cmd_t cur_q;
  logic rdv_q, rdv_d;
  logic [IDX_W-1:0] rdidx_q;
  logic [SORT_W-1:0] lastk_q, lastk_d, best_q, best_d;
  logic have_q, have_d, found_q, found_d;
  logic [IDX_W-1:0] pend_q, pend_d;
  logic pendv_q, pendv_d;
  logic outv_q, outv_d;
  logic [IDX_W-1:0] oidx_q, e_idx;
  logic ov_q, e_v;
  logic [1:0] ost_q, e_st;
  logic olast_q, e_last;
  logic emit, out_free;

  logic signed [4:0] lvl, minl, maxl;
  logic chk, lvl_ok, near, win, hit;
  logic signed [16:0] ddx, ddy;
  logic [16:0] adx, ady;
  logic signed [WIN_W-1:0] col_s, row_s;
  logic [SORT_W-1:0] key;

  assign out_free      = !outv_q || out_ready_i;
  assign out_valid_o   = outv_q;
  assign key_index_o   = oidx_q;
  assign index_valid_o = ov_q;
  assign status_o      = ost_q;
  assign last_o        = olast_q;
  assign stat_o.count  = count_q;

  // Match test for the entry read in the previous cycle.
  always_comb begin
    lvl    = $signed({2'b00, rd_q.level});
    minl   = 5'(cur_q.min_level);
    maxl   = 5'(cur_q.max_level);
    chk    = (minl > 5'sd0) || (maxl >= 5'sd0);
    lvl_ok = !chk || (!(lvl < minl) && !(maxl >= 5'sd0 && lvl > maxl));
    ddx    = 17'(rd_q.x) - 17'(cur_q.px);
    ddy    = 17'(rd_q.y) - 17'(cur_q.py);
    adx    = ddx[16] ? 17'(-ddx) : 17'(ddx);
    ady    = ddy[16] ? 17'(-ddy) : 17'(ddy);
    near   = (adx < {2'b00, cur_q.radius}) && (ady < {2'b00, cur_q.radius});
    col_s  = $signed({{(WIN_W-CELL_W){1'b0}}, rd_q.col});
    row_s  = $signed({{(WIN_W-CELL_W){1'b0}}, rd_q.row});
    win    = (col_s >= cur_q.c0) && (col_s <= cur_q.c1) &&
             (row_s >= cur_q.r0) && (row_s <= cur_q.r1);
    hit    = rdv_q && rd_q.in_grid && win && lvl_ok && near;
    key    = {rd_q.col, rd_q.row, rdidx_q};
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    addr_d  = addr_q;
    rdv_d   = 1'b0;
    lastk_d = lastk_q;
    have_d  = have_q;
    best_d  = best_q;
    found_d = found_q;
    pend_d  = pend_q;
    pendv_d = pendv_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    emit    = 1'b0;
    e_idx   = '0;
    e_v     = 1'b0;
    e_st    = ST_OK;
    e_last  = 1'b1;
    wdata.x       = head_i.px;
    wdata.y       = head_i.py;
    wdata.level   = head_i.octave;
    wdata.col     = head_i.col;
    wdata.row     = head_i.row;
    wdata.in_grid = head_i.in_grid;

    case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty && out_free) begin
          pop_o = 1'b1;
          case (head_i.kind)
            REQ_INSERT: begin
              emit = 1'b1;
              if (count_q == CNT_W'(MAX_KEYS)) begin
                e_st = ST_FULL;
              end else begin
                we      = 1'b1;
                e_idx   = count_q[IDX_W-1:0];
                e_v     = 1'b1;
                e_st    = head_i.in_grid ? ST_OK : ST_OUTSIDE;
                count_d = count_q + 1'b1;
              end
            end
            REQ_QUERY: begin
              addr_d  = '0;
              have_d  = 1'b0;
              found_d = 1'b0;
              pendv_d = 1'b0;
              state_d = B_SCAN;
            end
            REQ_CLEAR: begin
              emit    = 1'b1;
              count_d = '0;
            end
            default: ;
          endcase
        end
      end
      B_SCAN: begin
        if (addr_q < count_q) begin
          rdv_d  = 1'b1;
          addr_d = addr_q + 1'b1;
        end else if (!rdv_q) begin
          state_d = B_END;
        end
        if (hit && (!have_q || key > lastk_q) && (!found_q || key < best_q)) begin
          best_d  = key;
          found_d = 1'b1;
        end
      end
      B_END: begin
        if (found_q) begin
          if (!pendv_q || out_free) begin
            if (pendv_q) begin
              emit   = 1'b1;
              e_idx  = pend_q;
              e_v    = 1'b1;
              e_last = 1'b0;
            end
            pend_d  = best_q[IDX_W-1:0];
            pendv_d = 1'b1;
            lastk_d = best_q;
            have_d  = 1'b1;
            found_d = 1'b0;
            addr_d  = '0;
            state_d = B_SCAN;
          end
        end else if (out_free) begin
          emit    = 1'b1;
          e_idx   = pendv_q ? pend_q : '0;
          e_v     = pendv_q;
          e_st    = pendv_q ? ST_OK : ST_NOHIT;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (emit) outv_d = 1'b1;
    else if (out_ready_i) outv_d = 1'b0;
    else outv_d = outv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      count_q <= '0;
      addr_q  <= '0;
      rdv_q   <= 1'b0;
      have_q  <= 1'b0;
      found_q <= 1'b0;
      pendv_q <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      rdv_q   <= rdv_d;
      have_q  <= have_d;
      found_q <= found_d;
      pendv_q <= pendv_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[count_q[IDX_W-1:0]] <= wdata;
    rd_q    <= mem[addr_q[IDX_W-1:0]];
    rdidx_q <= addr_q[IDX_W-1:0];
    if (pop_o) cur_q <= head_i;
    lastk_q <= lastk_d;
    best_q  <= best_d;
    pend_q  <= pend_d;
    if (emit) begin
      oidx_q  <= e_idx;
      ov_q    <= e_v;
      ost_q   <= e_st;
      olast_q <= e_last;
    end
  end

endmodule

### rtl/keypoint_grid_radius_search_top.sv
// Flow: an insert or clear result leaves after the front end's multiply and cell
// stages and the command queue; a query scans the store once per hit plus once more.
// Throughput: the front end holds one transaction at a time (multiply path);
// query time is set by the single read port of the keypoint store.
// Reset: asynchronous active low; clears control state, the key count and loads
// the configuration defaults. The store itself is never cleared.
`include "keypoint_grid_radius_search_top_defines.svh"

module keypoint_grid_radius_search_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         req_type_i,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  input  logic [2:0]         octave_i,
  input  logic [14:0]        radius_i,
  input  logic signed [3:0]  min_level_i,
  input  logic signed [3:0]  max_level_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [5:0]         key_index_o,
  output logic               index_valid_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import kgrs_pkg::*;

  cfg_t   cfg_q;
  cmd_t   push_cmd, head_cmd;
  qstat_t qstat;
  bstat_t bstat;
  logic   push, pop;

  // Configuration writes are always taken; the user must issue them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x <= '0;
      cfg_q.origin_y <= '0;
      cfg_q.inv_w    <= 16'd6554;
      cfg_q.inv_h    <= 16'd6554;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: cfg_q.origin_x <= $signed(cfg_data_i);
        CFG_ORIGIN_Y: cfg_q.origin_y <= $signed(cfg_data_i);
        CFG_INV_W:    cfg_q.inv_w    <= cfg_data_i;
        CFG_INV_H:    cfg_q.inv_h    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end takes one transaction, scales it to grid cells and queues
  // a classified command.
  kgrs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .octave_i    (octave_i),
    .radius_i    (radius_i),
    .min_level_i (min_level_i),
    .max_level_i (max_level_i),
    .cfg_i       (cfg_q),
    .qstat_i     (qstat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  // Short command queue so the front end keeps going while a query scans.
  kgrs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .qstat_o (qstat)
  );

  // The back end owns the store; queries emit hits in (column, row, index)
  // order by repeated selection passes over the stored keypoints.
  kgrs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .key_index_o   (key_index_o),
    .index_valid_o (index_valid_o),
    .status_o      (status_o),
    .last_o        (last_o),
    .stat_o        (bstat)
  );

  // The front end never pushes into a full queue.
  `KGRS_ASSERT_NOW(a_no_overflow, push, !qstat.full, "command queue overflow")

  // The front end holds one transaction at a time.
  `KGRS_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o,
                    "front end took a second transaction")

  // A full-store result is only reported when the store really is full.
  `KGRS_ASSERT_NOW(a_full_status, out_valid_o && status_o == ST_FULL,
                   bstat.count == CNT_W'(MAX_KEYS), "full status with free entries")

endmodule

### tb/sv/tb_keypoint_grid_radius_search_top.sv
`timescale 1ns / 1ps

module tb_keypoint_grid_radius_search_top;
  import kgrs_pkg::*;

  // One pending request as the driver presents it on the input channel.
  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic [2:0]         octave;
    logic [14:0]        radius;
    logic signed [3:0]  min_level;
    logic signed [3:0]  max_level;
  } request_t;

  // One result transaction as it leaves the block.
  typedef struct {
    logic [5:0] key_index;
    logic       index_valid;
    logic [1:0] status;
    logic       last;
  } answer_t;

  localparam int LIMIT_CYCLES = 1500000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = CFG_ORIGIN_X;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         req_type_i = REQ_INSERT;
  logic signed [15:0] point_x_i = '0;
  logic signed [15:0] point_y_i = '0;
  logic [2:0]         octave_i = '0;
  logic [14:0]        radius_i = '0;
  logic signed [3:0]  min_level_i = '0;
  logic signed [3:0]  max_level_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [5:0]         key_index_o;
  logic               index_valid_o;
  logic [1:0]         status_o;
  logic               last_o;

  keypoint_grid_radius_search_top u_dut (.*);

  always #4 clk_i = ~clk_i;

  // Predictor state: configuration and a private copy of the keypoint store.
  logic signed [15:0] org_x, org_y;
  logic [15:0]        inv_w, inv_h;
  logic signed [15:0] kp_x [MAX_KEYS];
  logic signed [15:0] kp_y [MAX_KEYS];
  logic [2:0]         kp_level [MAX_KEYS];
  int                 kp_col [MAX_KEYS];
  int                 kp_row [MAX_KEYS];
  bit                 kp_in_grid [MAX_KEYS];
  int                 kp_count;

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  longint   cycle_count = 0;
  bit       hold_sender = 1'b0;

  // Exact rounding of a product carrying FRAC_BITS fraction bits.
  function automatic longint round_half_away(longint v);
    longint half = longint'(1) << (FRAC_BITS - 1);
    if (v >= 0) return (v + half) >>> FRAC_BITS;
    return -((-v + half) >>> FRAC_BITS);
  endfunction

  function automatic longint floor_cell(longint v);
    longint one = longint'(1) << FRAC_BITS;
    if (v >= 0) return v >>> FRAC_BITS;
    return -((-v + one - 1) >>> FRAC_BITS);
  endfunction

  function automatic longint ceil_cell(longint v);
    longint one = longint'(1) << FRAC_BITS;
    if (v >= 0) return (v + one - 1) >>> FRAC_BITS;
    return -((-v) >>> FRAC_BITS);
  endfunction

  function automatic void push_answer(logic [5:0] idx, logic vld, logic [1:0] st,
                                      logic lst);
    answer_t a;
    a.key_index = idx;
    a.index_valid = vld;
    a.status = st;
    a.last = lst;
    expected_answers.insert(expected_answers.size(), a);
  endfunction

  // Appends one request to the driver's queue.
  function automatic void queue_request(request_t q);
    pending_requests.insert(pending_requests.size(), q);
  endfunction

  // Works out every result of one accepted request and updates the store copy.
  function automatic void predict_search(request_t q);
    longint px, py, r, cx, cy, c0, c1, r0, r1, dx, dy;
    bit     ing, filt;
    int     hits[$];
    px = q.px;
    py = q.py;
    r = q.radius;
    case (q.kind)
      REQ_INSERT: begin
        if (kp_count >= MAX_KEYS) begin
          push_answer('0, 1'b0, ST_FULL, 1'b1);
        end else begin
          cx = round_half_away((px - org_x) * longint'(inv_w));
          cy = round_half_away((py - org_y) * longint'(inv_h));
          ing = cx >= 0 && cx < GRID_COLS && cy >= 0 && cy < GRID_ROWS;
          kp_x[kp_count] = q.px;
          kp_y[kp_count] = q.py;
          kp_level[kp_count] = q.octave;
          kp_col[kp_count] = ing ? int'(cx) : 0;
          kp_row[kp_count] = ing ? int'(cy) : 0;
          kp_in_grid[kp_count] = ing;
          push_answer(kp_count[5:0], 1'b1, ing ? ST_OK : ST_OUTSIDE, 1'b1);
          kp_count++;
        end
      end
      REQ_QUERY: begin
        filt = (q.min_level > 0) || (q.max_level >= 0);
        c0 = floor_cell((px - org_x - r) * longint'(inv_w));
        c1 = ceil_cell((px - org_x + r) * longint'(inv_w));
        r0 = floor_cell((py - org_y - r) * longint'(inv_h));
        r1 = ceil_cell((py - org_y + r) * longint'(inv_h));
        if (c0 < 0) c0 = 0;
        if (c1 > GRID_COLS - 1) c1 = GRID_COLS - 1;
        if (r0 < 0) r0 = 0;
        if (r1 > GRID_ROWS - 1) r1 = GRID_ROWS - 1;
        for (longint ix = c0; ix <= c1; ix++) begin
          for (longint iy = r0; iy <= r1; iy++) begin
            for (int k = 0; k < kp_count; k++) begin
              if (!kp_in_grid[k] || kp_col[k] != ix || kp_row[k] != iy) continue;
              if (filt && (int'(kp_level[k]) < int'(q.min_level))) continue;
              if (filt && q.max_level >= 0 && int'(kp_level[k]) > int'(q.max_level))
                continue;
              dx = longint'(kp_x[k]) - px;
              dy = longint'(kp_y[k]) - py;
              if (dx < 0) dx = -dx;
              if (dy < 0) dy = -dy;
              if (dx < r && dy < r) hits.insert(hits.size(), k);
            end
          end
        end
        if (hits.size() == 0) begin
          push_answer('0, 1'b0, ST_NOHIT, 1'b1);
        end else begin
          foreach (hits[h]) push_answer(hits[h][5:0], 1'b1, ST_OK, h == hits.size() - 1);
        end
      end
      REQ_CLEAR: begin
        kp_count = 0;
        push_answer('0, 1'b0, ST_OK, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic request_t make_request(logic [1:0] kind, int x, int y, int oct,
                                            int rad, int lo, int hi);
    request_t q;
    q.kind = kind;
    q.px = x[15:0];
    q.py = y[15:0];
    q.octave = oct[2:0];
    q.radius = rad[14:0];
    q.min_level = lo[3:0];
    q.max_level = hi[3:0];
    return q;
  endfunction

  // Random request: mostly keypoints inside the default grid area (64x48 cells of
  // about 160 px) and queries near them, with some full-range noise.
  function automatic request_t random_request();
    int sel = $urandom_range(0, 99);
    int wide = $urandom_range(0, 9) == 0;
    int x = wide ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 640 * 16);
    int y = wide ? $urandom_range(0, 65535) - 32768 : $urandom_range(0, 480 * 16);
    int rad = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32767)
                                           : $urandom_range(0, 1200);
    int lo = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) - 1 : 0;
    int hi = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) - 1 : -1;
    logic [1:0] kind;
    if (sel < 55) kind = REQ_INSERT;
    else if (sel < 93) kind = REQ_QUERY;
    else if (sel < 96) kind = REQ_CLEAR;
    else kind = REQ_NONE;
    return make_request(kind, x, y, $urandom_range(0, 7), rad, lo, hi);
  endfunction

  // Input driver: draws a gap before every transaction and holds valid until taken.
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_search(pending_requests.pop_front());
        in_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        in_valid_i <= 1'b0;
      end else if (!in_valid_i && pending_requests.size() > 0 && !hold_sender) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_requests[0].kind;
          point_x_i <= pending_requests[0].px;
          point_y_i <= pending_requests[0].py;
          octave_i <= pending_requests[0].octave;
          radius_i <= pending_requests[0].radius;
          min_level_i <= pending_requests[0].min_level;
          max_level_i <= pending_requests[0].max_level;
        end
      end
    end
  end

  // Output monitor: random stalls on ready, compares each transaction in order.
  int out_gap = 0;
  always @(posedge clk_i) begin
    answer_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result idx=%0d vld=%0b st=%0d last=%0b",
                     key_index_o, index_valid_o, status_o, last_o);
        end else begin
          e = expected_answers.pop_front();
          if (e.key_index !== key_index_o || e.index_valid !== index_valid_o ||
              e.status !== status_o || e.last !== last_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: exp idx=%0d vld=%0b st=%0d last=%0b, got %0d %0b %0d %0b",
                       e.key_index, e.index_valid, e.status, e.last,
                       key_index_o, index_valid_o, status_o, last_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i)
          out_gap <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Blocks until the queue has drained and every expected result has arrived,
  // then lets a full query scan pass so the block is truly idle.
  task automatic wait_idle();
    while (pending_requests.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // Presents one register write and waits for its acceptance; valid stays high
  // so that writes can follow back to back, the caller drops it at the end.
  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_ORIGIN_X: org_x = value;
      CFG_ORIGIN_Y: org_y = value;
      CFG_INV_W:    inv_w = value;
      default:      inv_h = value;
    endcase
  endtask

  task automatic configure(int ox, int oy, int iw, int ih);
    write_register(CFG_ORIGIN_X, ox[15:0]);
    write_register(CFG_ORIGIN_Y, oy[15:0]);
    write_register(CFG_INV_W, iw[15:0]);
    write_register(CFG_INV_H, ih[15:0]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int n);
    repeat (n) queue_request(random_request());
    wait_idle();
  endtask

  initial begin
    org_x = 0;
    org_y = 0;
    inv_w = 16'd6554;
    inv_h = 16'd6554;
    kp_count = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset configuration: grid corners, off-grid insert,
    // level filters, zero and full radius, ignored request type and clear.
    queue_request(make_request(REQ_QUERY, 0, 0, 0, 100, 0, -1));
    queue_request(make_request(REQ_INSERT, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(REQ_INSERT, 32767, 32767, 7, 0, 0, 0));
    queue_request(make_request(REQ_INSERT, -32768, -32768, 3, 0, 0, 0));
    queue_request(make_request(REQ_INSERT, 10 * 16 * 63, 10 * 16 * 47, 5,
                               0, 0, 0));
    queue_request(make_request(REQ_INSERT, 80, 80, 2, 0, 0, 0));
    queue_request(make_request(REQ_INSERT, 88, 72, 6, 0, 0, 0));
    queue_request(make_request(REQ_QUERY, 80, 80, 0, 32767, -1, -1));
    queue_request(make_request(REQ_QUERY, 80, 80, 0, 0, 0, -1));
    queue_request(make_request(REQ_QUERY, 80, 80, 0, 400, 3, -1));
    queue_request(make_request(REQ_QUERY, 80, 80, 0, 400, 0, 2));
    queue_request(make_request(REQ_QUERY, 80, 80, 0, 400, 7, 7));
    queue_request(make_request(REQ_QUERY, -32768, 32767, 0, 32767, 0, 0));
    queue_request(make_request(REQ_NONE, 1, 1, 1, 1, 1, 1));
    queue_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_request(make_request(REQ_QUERY, 80, 80, 0, 32767, -1, -1));
    wait_idle();

    // Fill the store past its capacity to reach the full status.
    for (int i = 0; i < MAX_KEYS + 2; i++)
      queue_request(make_request(REQ_INSERT, i * 37, i * 29, i % 8, 0, 0, 0));
    queue_request(make_request(REQ_QUERY, 600, 500, 0, 32767, -1, -1));
    wait_idle();

    // Sender held off with a clear request waiting, then released for a random phase.
    hold_sender = 1'b1;
    queue_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    repeat (30) @(posedge clk_i);
    hold_sender = 1'b0;
    random_phase(10);

    // Extremes of the configuration (negative and positive origin, zero and maximum inverse), then a moderate one.
    configure(-32768, 32767, 0, 65535);
    queue_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    random_phase(10);
    configure(32767, -32768, 65535, 0);
    queue_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    random_phase(10);
    configure(160, -80, 13107, 3277);
    queue_request(make_request(REQ_CLEAR, 0, 0, 0, 0, 0, 0));
    random_phase(12);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
